// File: rtl/single_wire_humidity_sensor_reader_core_macros.svh
// Assertion macros used by the humidity sensor reader top level.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_CORE_MACROS_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SWHR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swhr assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SWHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swhr assertion failed");

`endif

// File: rtl/swhr_pkg.sv
// Shared types and constants for the humidity sensor reader.
package swhr_pkg;

  localparam int unsigned TIMER_BITS     = 16;
  localparam int unsigned FRAME_EDGES    = 43;
  localparam int unsigned PREAMBLE_EDGES = 3;
  localparam int unsigned FRAME_BITS     = 40;
  localparam int unsigned EDGE_CNT_W     = 6;
  localparam int unsigned CFG_IDX_W      = 4;
  localparam int unsigned CFG_DATA_W     = 16;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_EDGE  = 2'd2;
  localparam logic [1:0] FUNC_FETCH = 2'd3;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_POWERUP = 3'd1;
  localparam logic [2:0] PH_REQUEST = 3'd2;
  localparam logic [2:0] PH_CAPTURE = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REQUEST   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(3);

  typedef struct packed {
    logic [1:0]            func;
    logic [TIMER_BITS-1:0] edge_time;
  } swhr_in_t;

  typedef struct packed {
    logic        drive_low;
    logic        idle;
    logic        reading_valid;
    logic [15:0] humidity_tenths;
    logic [15:0] temperature_tenths;
    logic        frame_done;
    logic        checksum_error;
    logic        timed_out;
  } swhr_out_t;

  typedef struct packed {
    logic [15:0]           interval_ms;
    logic [7:0]            request_ms;
    logic [5:0]            timeout_ms;
    logic [TIMER_BITS-1:0] bit_threshold;
  } swhr_cfg_t;

endpackage

// File: rtl/single_wire_humidity_sensor_reader_core.sv
// Top level of the single-wire humidity sensor reader: input and result registers.
//
//   channel | direction | handshake              | payload
//   in      | in        | in_valid_i / in_ready_o   | in_data_i (swhr_in_t)
//   out     | out       | out_valid_o / out_ready_i | out_data_o (swhr_out_t)
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction per cycle while the result side is not stalled; an accepted item
// is held in the input register and goes through the update logic to the result register.
// rst_ni clears the reader state and loads the register defaults.
// A stalled result holds the input register; the input side stalls only when
// both registers are full and out_ready_i is low. Config writes are always accepted.
`include "single_wire_humidity_sensor_reader_core_macros.svh"

module single_wire_humidity_sensor_reader_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  swhr_pkg::swhr_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output swhr_pkg::swhr_out_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [swhr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [swhr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import swhr_pkg::*;

  logic      in_valid_q, in_valid_d;
  swhr_in_t  in_data_q;
  logic      out_valid_q, out_valid_d;
  swhr_out_t out_data_q;
  swhr_out_t res;
  swhr_cfg_t cfg;
  logic      advance;

  swhr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  swhr_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (in_data_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // advance the held transaction when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_data_q <= in_data_i;
    if (advance) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SWHR_ASSERT_SAME(a_done_goes_idle, clk_i, rst_ni,
                    out_valid_o && out_data_o.frame_done, out_data_o.idle)
  `SWHR_ASSERT_SAME(a_timeout_to_powerup, clk_i, rst_ni, out_valid_o && out_data_o.timed_out,
                    !out_data_o.idle && !out_data_o.drive_low)
  `SWHR_ASSERT_SAME(a_cerr_clears_valid, clk_i, rst_ni, out_valid_o && out_data_o.checksum_error,
                    out_data_o.frame_done && !out_data_o.reading_valid)
  `SWHR_ASSERT_SAME(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o,
                    out_valid_o && !out_ready_i)

endmodule

// File: rtl/swhr_cfg.sv
// Configuration register file of the humidity sensor reader.
module swhr_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [swhr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [swhr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output swhr_pkg::swhr_cfg_t              cfg_o
);
  import swhr_pkg::*;

  swhr_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_INTERVAL:  cfg_d.interval_ms   = cfg_data_i[15:0];
        REG_REQUEST:   cfg_d.request_ms    = cfg_data_i[7:0];
        REG_TIMEOUT:   cfg_d.timeout_ms    = cfg_data_i[5:0];
        REG_THRESHOLD: cfg_d.bit_threshold = cfg_data_i[TIMER_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_ms   <= 16'd2000;
      cfg_q.request_ms    <= 8'd2;
      cfg_q.timeout_ms    <= 6'd6;
      cfg_q.bit_threshold <= TIMER_BITS'(100);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/swhr_step.sv
// Reader state and single-pass update logic for one transaction.
module swhr_step (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_en_i,
  input  swhr_pkg::swhr_in_t    item_i,
  input  swhr_pkg::swhr_cfg_t   cfg_i,
  output swhr_pkg::swhr_out_t   res_o
);
  import swhr_pkg::*;

  localparam logic [EDGE_CNT_W-1:0] LAST_EDGE = EDGE_CNT_W'(FRAME_EDGES);
  localparam logic [EDGE_CNT_W-1:0] DATA_EDGE = EDGE_CNT_W'(PREAMBLE_EDGES);

  logic [2:0]            phase_q, phase_d;
  logic [15:0]           since_q, since_d;
  logic [7:0]            timer_q, timer_d;
  logic [EDGE_CNT_W-1:0] edge_cnt_q, edge_cnt_d;
  logic [TIMER_BITS-1:0] last_edge_q, last_edge_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;
  logic                  valid_q, valid_d, valid_mid;
  logic [15:0]           hum_q, hum_d;
  logic [15:0]           temp_q, temp_d;

  logic [15:0]           since_inc;
  logic [7:0]            timer_inc;
  logic [TIMER_BITS-1:0] gap;
  logic [FRAME_BITS-1:0] frame_sh;
  logic [7:0]            sum8;
  logic                  done, cerr, tout;

  assign since_inc = (since_q == 16'hFFFF) ? since_q : since_q + 16'd1;
  assign timer_inc = (timer_q == 8'hFF) ? timer_q : timer_q + 8'd1;
  assign gap       = item_i.edge_time - last_edge_q;
  assign frame_sh  = {frame_q[FRAME_BITS-2:0], (gap > cfg_i.bit_threshold)};
  // the closing edge always carries a data bit, so the frame checked is the shifted one
  assign sum8      = frame_sh[39:32] + frame_sh[31:24] + frame_sh[23:16] + frame_sh[15:8];

  always_comb begin
    phase_d     = phase_q;
    since_d     = since_q;
    timer_d     = timer_q;
    edge_cnt_d  = edge_cnt_q;
    last_edge_d = last_edge_q;
    frame_d     = frame_q;
    valid_mid   = valid_q;
    hum_d       = hum_q;
    temp_d      = temp_q;
    done        = 1'b0;
    cerr        = 1'b0;
    tout        = 1'b0;

    case (item_i.func)
      FUNC_START: begin
        if (phase_q == PH_IDLE) phase_d = PH_POWERUP;
      end
      FUNC_TICK: begin
        since_d = since_inc;
        if (phase_q == PH_POWERUP) begin
          if (since_inc > cfg_i.interval_ms) begin
            phase_d = PH_REQUEST;
            timer_d = 8'd0;
          end
        end else if (phase_q == PH_REQUEST) begin
          timer_d = timer_inc;
          if (timer_inc >= cfg_i.request_ms) begin
            phase_d    = PH_CAPTURE;
            timer_d    = 8'd0;
            edge_cnt_d = '0;
            frame_d    = '0;
          end
        end else if (phase_q == PH_CAPTURE) begin
          timer_d = timer_inc;
          if (timer_inc > {2'b00, cfg_i.timeout_ms}) begin
            tout    = 1'b1;
            phase_d = PH_POWERUP;
            since_d = 16'd0;
          end
        end
      end
      FUNC_EDGE: begin
        if (phase_q == PH_CAPTURE && edge_cnt_q < LAST_EDGE) begin
          if (edge_cnt_q >= DATA_EDGE) begin
            frame_d = frame_sh;
          end
          last_edge_d = item_i.edge_time;
          edge_cnt_d  = edge_cnt_q + EDGE_CNT_W'(1);
          if (edge_cnt_d == LAST_EDGE) begin
            done    = 1'b1;
            phase_d = PH_IDLE;
            since_d = 16'd0;
            if (frame_sh[7:0] == sum8) begin
              hum_d     = frame_sh[39:24];
              temp_d    = frame_sh[23:8];
              valid_mid = 1'b1;
            end else begin
              valid_mid = 1'b0;
              cerr      = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    // fetch reports the flag as it stood, then drops it
    valid_d = (item_i.func == FUNC_FETCH) ? 1'b0 : valid_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      since_q     <= '0;
      timer_q     <= '0;
      edge_cnt_q  <= '0;
      last_edge_q <= '0;
      frame_q     <= '0;
      valid_q     <= 1'b0;
      hum_q       <= '0;
      temp_q      <= '0;
    end else if (step_en_i) begin
      phase_q     <= phase_d;
      since_q     <= since_d;
      timer_q     <= timer_d;
      edge_cnt_q  <= edge_cnt_d;
      last_edge_q <= last_edge_d;
      frame_q     <= frame_d;
      valid_q     <= valid_d;
      hum_q       <= hum_d;
      temp_q      <= temp_d;
    end
  end

  always_comb begin
    res_o.drive_low          = (phase_d == PH_REQUEST);
    res_o.idle               = (phase_d == PH_IDLE);
    res_o.reading_valid      = valid_mid;
    res_o.humidity_tenths    = hum_d;
    res_o.temperature_tenths = temp_d;
    res_o.frame_done         = done;
    res_o.checksum_error     = cerr;
    res_o.timed_out          = tout;
  end

endmodule
